// ===== sv/sitda_pkg.sv =====
// shared types and constants for the signed integer to decimal text converter
`default_nettype none

package sitda_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned DIGIT_MAX = 10;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned PROD_W    = 64;
   localparam int unsigned RECIP_SH  = 35;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   // floor(n / 10) == (n * RECIP_TEN) >> 35 for every 32-bit n
   localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

   typedef logic [3:0] digit_type;
   typedef digit_type [DIGIT_MAX-1:0] digit_array_type;

   typedef struct packed {
      logic               negative;
      logic [VALUE_W-1:0] magnitude;
   } item_type;

   typedef struct packed {
      logic               negative;
      logic [COUNT_W-1:0] count;
      digit_array_type    digits;
   } handoff_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_DIVIDE,
      CONV_HANDOFF
   } conv_state_type;

endpackage

`default_nettype wire

// ===== sv/sitda_front.sv =====
// input stage: takes an item, works out sign and magnitude
`default_nettype none

module sitda_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output sitda_pkg::item_type                push_item
);

   logic                valid_ff;
   logic                valid_in;
   sitda_pkg::item_type item_ff;
   sitda_pkg::item_type item_in;
   logic [sitda_pkg::VALUE_W-1:0] raw;

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      raw                = req_value;
      item_in.negative   = raw[sitda_pkg::VALUE_W-1];
      // two's complement magnitude, the most negative value gives 2^31 unsigned
      item_in.magnitude  = raw[sitda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
      valid_in           = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sitda_queue.sv =====
// short item queue between the input stage and the converter
`default_nettype none

module sitda_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire sitda_pkg::item_type push_item,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output sitda_pkg::item_type      pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sitda_pkg::item_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != CNT_FULL);
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sitda_conv.sv =====
// digit extraction: one division by ten per cycle, least significant digit first
`default_nettype none

module sitda_conv (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire sitda_pkg::item_type  pop_item,
   output logic                      hand_valid,
   input  wire logic                 hand_ready,
   output sitda_pkg::handoff_type    hand_data
);

   sitda_pkg::conv_state_type state_ff, state_in;

   logic                              neg_ff;
   logic [sitda_pkg::VALUE_W-1:0]     mag_ff;
   logic [sitda_pkg::COUNT_W-1:0]     count_ff;
   sitda_pkg::digit_array_type        digits_ff;

   logic [sitda_pkg::PROD_W-1:0]      prod;
   logic [sitda_pkg::VALUE_W-1:0]     quot;
   logic [sitda_pkg::VALUE_W-1:0]     ten_quot;
   logic [sitda_pkg::VALUE_W-1:0]     diff;
   sitda_pkg::digit_type              rem;

   always_comb begin
      prod     = sitda_pkg::PROD_W'(mag_ff) * sitda_pkg::PROD_W'(sitda_pkg::RECIP_TEN);
      quot     = sitda_pkg::VALUE_W'(prod >> sitda_pkg::RECIP_SH);
      ten_quot = (quot << 3) + (quot << 1);
      diff     = mag_ff - ten_quot;
      rem      = diff[3:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sitda_pkg::CONV_IDLE: begin
            if (pop_valid) begin
               state_in = sitda_pkg::CONV_DIVIDE;
            end
         end
         sitda_pkg::CONV_DIVIDE: begin
            if (quot == '0) begin
               state_in = sitda_pkg::CONV_HANDOFF;
            end
         end
         sitda_pkg::CONV_HANDOFF: begin
            if (hand_ready) begin
               state_in = sitda_pkg::CONV_IDLE;
            end
         end
         default: state_in = sitda_pkg::CONV_IDLE;
      endcase
   end

   always_comb begin
      pop_ready  = 1'b0;
      hand_valid = 1'b0;
      unique case (state_ff)
         sitda_pkg::CONV_IDLE:    pop_ready  = 1'b1;
         sitda_pkg::CONV_DIVIDE:  pop_ready  = 1'b0;
         sitda_pkg::CONV_HANDOFF: hand_valid = 1'b1;
         default:                 pop_ready  = 1'b0;
      endcase
   end

   assign hand_data.negative = neg_ff;
   assign hand_data.count    = count_ff;
   assign hand_data.digits   = digits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitda_pkg::CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sitda_pkg::CONV_IDLE && pop_valid) begin
         neg_ff   <= pop_item.negative;
         mag_ff   <= pop_item.magnitude;
         count_ff <= '0;
      end else if (state_ff == sitda_pkg::CONV_DIVIDE) begin
         digits_ff[count_ff] <= rem;
         count_ff            <= count_ff + 1'b1;
         mag_ff              <= quot;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sitda_emit.sv =====
// character output: sign, then digits from the most significant down
`default_nettype none

module sitda_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   hand_valid,
   output logic                        hand_ready,
   input  wire sitda_pkg::handoff_type hand_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last
);

   logic                          busy_ff, busy_in;
   logic                          sign_ff, sign_in;
   logic [sitda_pkg::COUNT_W-1:0] idx_ff, idx_in;
   sitda_pkg::digit_array_type    digits_ff;
   logic                          take;
   logic                          load;

   assign rsp_valid     = busy_ff;
   assign rsp_last      = !sign_ff && (idx_ff == '0);
   assign rsp_character = sign_ff ? sitda_pkg::ASCII_MINUS
                                  : sitda_pkg::ASCII_ZERO + {4'b0, digits_ff[idx_ff]};
   assign take          = rsp_valid && rsp_ready;
   assign hand_ready    = !busy_ff || (take && rsp_last);
   assign load          = hand_valid && hand_ready;

   always_comb begin
      busy_in = busy_ff;
      sign_in = sign_ff;
      idx_in  = idx_ff;
      if (take) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (idx_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         sign_in = hand_data.negative;
         idx_in  = hand_data.count - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sign_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sign_ff <= sign_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= hand_data.digits;
      end
   end

endmodule

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// top level of the signed integer to decimal ascii converter
//
//   channel | ports                          | direction | item
//   req     | req_valid req_ready req_value  | in        | signed 32-bit integer
//   rsp     | rsp_valid rsp_ready            | out       | one character per item,
//           |   rsp_character rsp_last       |           |   rsp_last on the final one
//
// a number with n digits holds the divide stage for n divisions and then the handoff
// the character stage sends n or n + 1 characters, one per cycle while rsp_ready
// is high, while the next number is divided
// synchronous active-high reset empties the input stage and the queue and idles both stages
// either side may stall at any time; the queue holds up to QUEUE_DEPTH waiting numbers
`default_nettype none

module signed_int_to_decimal_ascii #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [7:0]                                rsp_character,
   output logic                                      rsp_last
);

   logic                   push_valid, push_ready;
   sitda_pkg::item_type    push_item;
   logic                   pop_valid, pop_ready;
   sitda_pkg::item_type    pop_item;
   logic                   hand_valid, hand_ready;
   sitda_pkg::handoff_type hand_data;

   sitda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   sitda_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sitda_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .hand_valid (hand_valid),
      .hand_ready (hand_ready),
      .hand_data  (hand_data)
   );

   sitda_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .hand_valid    (hand_valid),
      .hand_ready    (hand_ready),
      .hand_data     (hand_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // only a minus sign or a decimal digit ever leaves
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sitda_pkg::ASCII_MINUS) ||
                    ((rsp_character >= sitda_pkg::ASCII_ZERO) &&
                     (rsp_character <= sitda_pkg::ASCII_ZERO + 8'd9)))
      else $error("character out of range");

   // a minus sign is always followed by at least one digit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_character == sitda_pkg::ASCII_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last");

   // the text of one number goes out without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("gap inside a number's text");

   // nothing leaves in the cycle after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("output valid straight after reset");

endmodule

`default_nettype wire

// ===== tb/sv/decimal_text_checker.sv =====
// checker for the decimal text converter: predicts the characters of each number and compares
`timescale 1ns / 100ps

module decimal_text_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic [7:0]                           rsp_character,
   input  wire logic                                 rsp_last,
   output int                                        failures,
   output int                                        outstanding
);

   localparam logic [32:0] TEN = 33'd10;

   typedef struct {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];
   int            error_count = 0;
   int            pending     = 0;

   assign failures    = error_count;
   assign outstanding = pending;

   task automatic queue_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] value);
      logic [32:0]   magnitude;
      logic [3:0]    digits[sitda_pkg::DIGIT_MAX];
      int            digit_count;
      text_char_type entry;
      begin
         digit_count = 0;
         if (value[sitda_pkg::VALUE_W-1]) begin
            magnitude = 33'h1_0000_0000 - {1'b0, value};
         end else begin
            magnitude = {1'b0, value};
         end
         // least significant digit first
         do begin
            digits[digit_count] = 4'(magnitude % TEN);
            digit_count++;
            magnitude = magnitude / TEN;
         end while (magnitude != 0);
         if (value[sitda_pkg::VALUE_W-1]) begin
            entry.character = sitda_pkg::ASCII_MINUS;
            entry.last      = 1'b0;
            expected_text.push_back(entry);
         end
         for (int k = digit_count - 1; k >= 0; k--) begin
            entry.character = sitda_pkg::ASCII_ZERO + 8'(digits[k]);
            entry.last      = (k == 0);
            expected_text.push_back(entry);
         end
      end
   endtask

   always @(posedge clock) begin
      text_char_type oldest;
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_decimal_text(req_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected item: character %0d last %0b", rsp_character, rsp_last);
               error_count++;
            end else begin
               oldest = expected_text.pop_front();
               if (rsp_character !== oldest.character) begin
                  $error("character: expected %0d, got %0d", oldest.character, rsp_character);
                  error_count++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("last: expected %0b, got %0b", oldest.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
      pending = expected_text.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the signed integer to decimal ascii converter
`timescale 1ns / 100ps

module tb;

   localparam int RANDOM_ITEMS   = 240;
   localparam int CALM_ITEMS     = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 30;

   logic                                 clock     = 1'b0;
   logic                                 reset     = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [sitda_pkg::VALUE_W-1:0] req_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [7:0]                           rsp_character;
   logic                                 rsp_last;
   int                                   failures;
   int                                   outstanding;
   bit                                   calm = 1'b0;
   int                                   sink_stall = 0;
   int                                   idle_cycles = 0;

   always #5 clock = ~clock;

   signed_int_to_decimal_ascii u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   decimal_text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .failures      (failures),
      .outstanding   (outstanding)
   );

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (sink_stall > 0) begin
         rsp_ready  <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else if (!calm && $urandom_range(7, 0) == 0) begin
         rsp_ready  <= 1'b0;
         sink_stall <= $urandom_range(17, 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_number(input logic [sitda_pkg::VALUE_W-1:0] value);
      int gap;
      begin
         gap = 0;
         if (!calm && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(18, 1);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_value <= $urandom;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_value <= value;
         do @(posedge clock); while (!req_ready);
      end
   endtask

   function automatic logic [sitda_pkg::VALUE_W-1:0] random_number();
      longint lo;
      longint hi;
      longint magnitude;
      int     digit_count;
      begin
         if ($urandom_range(1, 0) == 0) begin
            return $urandom;
         end
         // pick a digit count first so short and long texts are both common
         digit_count = $urandom_range(10, 1);
         lo = 1;
         repeat (digit_count - 1) lo = lo * 10;
         hi = lo * 10 - 1;
         if (digit_count == 1) begin
            lo = 0;
         end
         if (hi > 64'sd2147483647) begin
            hi = 64'sd2147483647;
         end
         magnitude = $urandom_range(int'(hi), int'(lo));
         if ($urandom_range(1, 0) == 1) begin
            if ($urandom_range(15, 0) == 0) begin
               magnitude = magnitude + 1;
            end
            return sitda_pkg::VALUE_W'(-magnitude);
         end
         return sitda_pkg::VALUE_W'(magnitude);
      end
   endfunction

   initial begin
      logic [sitda_pkg::VALUE_W-1:0] directed[$];
      directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                   32'sd99, 32'sd100, -32'sd100, 32'sd12345, -32'sd67890,
                   32'sd999999999, 32'sd1000000000, -32'sd1000000000,
                   32'sd2147483647, -32'sd2147483647, 32'h8000_0000,
                   32'sd1234567890, -32'sd987654321, 32'sd5, 32'h5555_5555,
                   32'hAAAA_AAAA};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_number(directed[i]);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
         end
         send_number(random_number());
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
